/* hw/rtl/tgcps_pkg.sv */
// Shared constants and types for the character-cell pixel serializer.
package tgcps_pkg;

    // Field widths.
    localparam int COLOR_W = 5;
    localparam int CFG_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int PIX_MAX = 16;
    localparam int CNT_W   = $clog2(PIX_MAX);

    // Configuration register indexes.
    localparam logic CFG_IDX_MODE  = 1'b0;
    localparam logic CFG_IDX_COLOR = 1'b1;

    // Mode register bit positions.
    localparam int MODE_80COL = 0;
    localparam int MODE_GRAPH = 1;
    localparam int MODE_MONO  = 2;
    localparam int MODE_VIDEO = 3;
    localparam int MODE_G640  = 4;
    localparam int MODE_BLINK = 5;

    // Color select bit positions.
    localparam int CSEL_INTENSITY = 4;
    localparam int CSEL_PALETTE   = 5;

    // Fixed palette codes.
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 5'd0;
    localparam logic [COLOR_W-1:0] COLOR_BASE  = 5'd16;

    // Index of the last pixel for the two cell widths.
    localparam logic [CNT_W-1:0] LAST_NARROW = 4'd7;
    localparam logic [CNT_W-1:0] LAST_WIDE   = 4'd15;

    // One rendered cell: pixel 0 goes out first.
    typedef struct packed {
        logic [PIX_MAX-1:0][COLOR_W-1:0] pix;
        logic [CNT_W-1:0]                last_idx;
    } cell_t;

endpackage

/* hw/rtl/text_graphics_cell_pixel_serializer_unit.sv */
// Top level of the character-cell pixel serializer: registers, cell buffer and shifter.
// An accepted item is registered in the cell buffer, then loaded into the shifter.
// One pixel per cycle while out_ready is high; an item gives 8 or 16 pixels.
// A one-cell buffer takes the next item while the current cell is still shifting out.
// Reset (rst_n, async, active low) clears both registers; buffer and shifter go empty.
module text_graphics_cell_pixel_serializer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [tgcps_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            sync_blank,
    input  logic                            vsync_gate,
    input  logic                            display_enable,
    input  logic                            cursor_on,
    input  logic                            blink_phase,
    input  logic                            dot_clock_high,
    input  logic [tgcps_pkg::BYTE_W-1:0]    first_byte,
    input  logic [tgcps_pkg::BYTE_W-1:0]    second_byte,
    input  logic [tgcps_pkg::BYTE_W-1:0]    glyph_row,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tgcps_pkg::COLOR_W-1:0]   pixel_color,
    output logic                            last_pixel
);
    import tgcps_pkg::*;

    logic [CFG_W-1:0] mode_reg, mode_next;
    logic [CFG_W-1:0] csel_reg, csel_next;
    cell_t            rendered;
    cell_t            buf_cell_reg, buf_cell_next;
    logic             buf_valid_reg, buf_valid_next;
    logic             ser_load;
    logic             ser_busy;
    logic             ser_finishing;
    logic             in_accept;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        mode_next = mode_reg;
        csel_next = csel_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IDX_MODE:  mode_next = cfg_data;
                CFG_IDX_COLOR: csel_next = cfg_data;
                default:       mode_next = mode_reg;
            endcase
        end
    end

    // Render the incoming item with the current configuration.
    tgcps_render u_render (
        .mode_register  (mode_reg),
        .color_select   (csel_reg),
        .sync_blank     (sync_blank),
        .vsync_gate     (vsync_gate),
        .display_enable (display_enable),
        .cursor_on      (cursor_on),
        .blink_phase    (blink_phase),
        .dot_clock_high (dot_clock_high),
        .first_byte     (first_byte),
        .second_byte    (second_byte),
        .glyph_row      (glyph_row),
        .cell_out       (rendered)
    );

    // Cell buffer: moves into the shifter when it is empty or sending its last pixel.
    assign ser_load  = buf_valid_reg && (!ser_busy || ser_finishing);
    assign in_ready  = !buf_valid_reg || ser_load;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        buf_cell_next  = buf_cell_reg;
        if (in_accept)
        begin
            buf_valid_next = 1'b1;
            buf_cell_next  = rendered;
        end
        else if (ser_load)
        begin
            buf_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= '0;
            csel_reg      <= '0;
            buf_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            csel_reg      <= csel_next;
            buf_valid_reg <= buf_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_cell_reg <= buf_cell_next;
    end

    // Pixel shifter feeding the result channel.
    tgcps_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (ser_load),
        .cell_in     (buf_cell_reg),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .busy        (ser_busy),
        .finishing   (ser_finishing),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

    // A cell never ends early: a taken pixel that is not the last is followed by another.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_pixel |=> out_valid)
        else $error("result stream stopped inside a cell");

    // An item taken while the buffer is full must coincide with the buffer draining.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && buf_valid_reg |-> ser_load)
        else $error("buffered cell overwritten");

    // The shifter is reloaded only when empty or on its final pixel.
    a_load_safe: assert property (@(posedge clk) disable iff (!rst_n)
        ser_load |-> (!out_valid || (out_ready && last_pixel)))
        else $error("shifter reloaded mid-cell");

endmodule

/* hw/rtl/tgcps_render.sv */
// Cell renderer: turns one character cell and the mode registers into a row of pixels.
module tgcps_render (
    input  logic [tgcps_pkg::CFG_W-1:0]  mode_register,
    input  logic [tgcps_pkg::CFG_W-1:0]  color_select,
    input  logic                         sync_blank,
    input  logic                         vsync_gate,
    input  logic                         display_enable,
    input  logic                         cursor_on,
    input  logic                         blink_phase,
    input  logic                         dot_clock_high,
    input  logic [tgcps_pkg::BYTE_W-1:0] first_byte,
    input  logic [tgcps_pkg::BYTE_W-1:0] second_byte,
    input  logic [tgcps_pkg::BYTE_W-1:0] glyph_row,
    output tgcps_pkg::cell_t             cell_out
);
    import tgcps_pkg::*;

    logic [COLOR_W-1:0]     bgc;
    logic [CNT_W-1:0]       width_last;
    logic [COLOR_W-1:0]     border;
    logic [COLOR_W-1:0]     blank;
    logic [COLOR_W-1:0]     fg;
    logic [COLOR_W-1:0]     bg;
    logic [7:0][COLOR_W-1:0] dot;
    logic [3:0][COLOR_W-1:0] cols;
    logic [2*BYTE_W-1:0]    dat;
    logic [COLOR_W-1:0]     base;

    assign bgc        = {1'b1, color_select[3:0]};
    assign width_last = dot_clock_high ? LAST_NARROW : LAST_WIDE;
    assign dat        = {first_byte, second_byte};

    // Border and blank colors for fill cells.
    always_comb
    begin
        border = (mode_register[MODE_GRAPH] && mode_register[MODE_G640]) ? COLOR_BLACK : bgc;
        if (!mode_register[MODE_GRAPH])
            blank = COLOR_BASE;
        else if (mode_register[MODE_G640])
            blank = COLOR_BLACK;
        else
            blank = bgc;
    end

    // Text foreground and background with blink handling, then the eight text dots.
    always_comb
    begin
        fg = {1'b1, second_byte[3:0]};
        if (mode_register[MODE_BLINK])
        begin
            bg = {2'b10, second_byte[6:4]};
            if (blink_phase && second_byte[7] && !cursor_on)
                fg = bg;
        end
        else
        begin
            bg = {1'b1, second_byte[7:4]};
        end
        for (int d = 0; d < 8; d++)
        begin
            dot[d] = glyph_row[7-d] ? fg : bg;
            if (cursor_on)
                dot[d] = dot[d] ^ 5'b01111;
        end
    end

    // Four-color palette for 320-wide graphics.
    always_comb
    begin
        base    = {1'b1, color_select[CSEL_INTENSITY], 3'b000};
        cols[0] = bgc;
        if (mode_register[MODE_MONO])
        begin
            cols[1] = base | 5'd3;
            cols[2] = base | 5'd4;
            cols[3] = base | 5'd7;
        end
        else if (color_select[CSEL_PALETTE])
        begin
            cols[1] = base | 5'd3;
            cols[2] = base | 5'd5;
            cols[3] = base | 5'd7;
        end
        else
        begin
            cols[1] = base | 5'd2;
            cols[2] = base | 5'd4;
            cols[3] = base | 5'd6;
        end
    end

    // Pick the cell form by priority: sync, display off, video off, then the drawing modes.
    always_comb
    begin
        cell_out = '0;
        if (sync_blank || vsync_gate)
        begin
            cell_out.last_idx = width_last;
            for (int k = 0; k < PIX_MAX; k++)
                cell_out.pix[k] = COLOR_BLACK;
        end
        else if (!display_enable)
        begin
            cell_out.last_idx = width_last;
            for (int k = 0; k < PIX_MAX; k++)
                cell_out.pix[k] = border;
        end
        else if (!mode_register[MODE_VIDEO])
        begin
            cell_out.last_idx = width_last;
            for (int k = 0; k < PIX_MAX; k++)
                cell_out.pix[k] = blank;
        end
        else if (mode_register[MODE_80COL])
        begin
            cell_out.last_idx = LAST_NARROW;
            for (int k = 0; k < 8; k++)
                cell_out.pix[k] = dot[k];
        end
        else if (!mode_register[MODE_GRAPH])
        begin
            cell_out.last_idx = LAST_WIDE;
            for (int k = 0; k < PIX_MAX; k++)
                cell_out.pix[k] = dot[k>>1];
        end
        else if (mode_register[MODE_G640])
        begin
            cell_out.last_idx = LAST_WIDE;
            for (int k = 0; k < PIX_MAX; k++)
                cell_out.pix[k] = dat[15-k] ? bgc : COLOR_BLACK;
        end
        else
        begin
            cell_out.last_idx = LAST_WIDE;
            for (int k = 0; k < PIX_MAX; k++)
                cell_out.pix[k] = cols[dat[15-2*(k>>1) -: 2]];
        end
    end

endmodule

/* hw/rtl/tgcps_serializer.sv */
// Pixel shifter: holds one rendered cell and sends out one pixel per accepted result.
module tgcps_serializer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  tgcps_pkg::cell_t                cell_in,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic                            busy,
    output logic                            finishing,
    output logic [tgcps_pkg::COLOR_W-1:0]   pixel_color,
    output logic                            last_pixel
);
    import tgcps_pkg::*;

    logic [PIX_MAX-1:0][COLOR_W-1:0] pix_reg, pix_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            valid_reg, valid_next;

    assign out_valid   = valid_reg;
    assign busy        = valid_reg;
    assign pixel_color = pix_reg[0];
    assign last_pixel  = (cnt_reg == '0);
    assign finishing   = valid_reg && out_ready && last_pixel;

    // Load a new cell, shift on each accepted pixel, or go empty after the last one.
    always_comb
    begin
        pix_next   = pix_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (load)
        begin
            pix_next   = cell_in.pix;
            cnt_next   = cell_in.last_idx;
            valid_next = 1'b1;
        end
        else if (valid_reg && out_ready)
        begin
            if (last_pixel)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                pix_next = pix_reg >> COLOR_W;
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state is reset; pixel data is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

endmodule
